// ----- sv/xcrc_pkg.sv -----
package xcrc_pkg;

	localparam int BLOCK_BYTES = 128;

	// frame byte positions
	localparam logic [7:0] POS_NUMBER     = 8'd1;
	localparam logic [7:0] POS_COMPLEMENT = 8'd2;
	localparam logic [7:0] POS_DATA_FIRST = 8'd3;
	localparam logic [7:0] POS_CRC_HIGH   = 8'(BLOCK_BYTES + 3);
	localparam logic [7:0] POS_CRC_LOW    = 8'(BLOCK_BYTES + 4);

	localparam logic [7:0]  CH_NONE  = 8'h00;
	localparam logic [7:0]  CH_SOH   = 8'h01;
	localparam logic [7:0]  CH_EOT   = 8'h04;
	localparam logic [7:0]  CH_ACK   = 8'h06;
	localparam logic [7:0]  CH_NAK   = 8'h15;
	localparam logic [7:0]  CH_C     = 8'h43;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_BYTE  = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	localparam logic [1:0] VD_NONE   = 2'd0;
	localparam logic [1:0] VD_COMMIT = 2'd1;
	localparam logic [1:0] VD_DROP   = 2'd2;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_BUSY = 2'd1;
	localparam logic [1:0] ST_OK   = 2'd2;
	localparam logic [1:0] ST_FAIL = 2'd3;

	localparam logic [1:0] CFG_TIMEOUT       = 2'd0;
	localparam logic [1:0] CFG_MAX_RETRIES   = 2'd1;
	localparam logic [1:0] CFG_START_RETRIES = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_RECV,
		PH_TRAIL,
		PH_OK,
		PH_FAIL
	} phase_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       data_valid;
		logic [7:0] data_byte;
		logic [6:0] data_index;
		logic [1:0] verdict;
		logic [1:0] status;
		logic       last;
	} res_item_t;

	// up to two results written to the result queue in one cycle
	typedef struct packed {
		logic [1:0] n;
		res_item_t  r0;
		res_item_t  r1;
	} res_pair_t;

	function automatic res_item_t mk_res(input logic [7:0] tx, input logic dv,
			input logic [7:0] db, input logic [6:0] di, input logic [1:0] vd);
		res_item_t r;
		r            = '0;
		r.tx_valid   = (tx != CH_NONE);
		r.tx_byte    = tx;
		r.data_valid = dv;
		r.data_byte  = dv ? db : 8'd0;
		r.data_index = dv ? di : 7'd0;
		r.verdict    = vd;
		return r;
	endfunction

	// CRC-16 over one byte, MSB first, eight shift steps
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15])
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			else
				c = {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// ----- sv/xcrc_res_fifo.sv -----
module xcrc_res_fifo #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  xcrc_pkg::res_pair_t wr,
	output logic              room,
	output logic              out_valid,
	input  logic              out_stall,
	output xcrc_pkg::res_item_t out_data
);
	import xcrc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	res_item_t         mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [PW-1:0]     wr_next;
	logic [PW-1:0]     wr_next2;
	logic [PW-1:0]     rd_next;
	logic [CW-1:0]     count_q;
	logic              pop;

	// pointers wrap at the last slot, any depth
	assign wr_next   = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
	assign wr_next2  = (wr_next == PW'(DEPTH - 1)) ? '0 : wr_next + PW'(1);
	assign rd_next   = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);

	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign pop       = out_valid && !out_stall;
	assign room      = (count_q <= CW'(DEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr.n == 2'd2)
				wr_ptr_q <= wr_next2;
			else if (wr.n == 2'd1)
				wr_ptr_q <= wr_next;
			if (pop)
				rd_ptr_q <= rd_next;
			count_q <= count_q + CW'(wr.n) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (wr.n != 2'd0)
			mem_q[wr_ptr_q] <= wr.r0;
		if (wr.n == 2'd2)
			mem_q[wr_next] <= wr.r1;
	end

endmodule

// ----- sv/xmodem_crc_receiver.sv -----
// Flow: a request is held in the input register, is decoded there and its results
//   enter the result queue when it advances; the first result is offered from the
//   queue after that write and can be taken while out_stall is low.
// Throughput: one request per cycle while the queue has room; two results leave one by one,
//   and the input stalls only when the result queue lacks room for two.
// Reset (arst_n low, asynchronous): idle, expected number 1, all counters and CRC zero,
//   registers to timeout 1000, max retries 4, start retries 1; queue empty.
module xmodem_crc_receiver #(
	parameter int RES_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  xcrc_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output xcrc_pkg::res_item_t out_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import xcrc_pkg::*;

	// configuration
	logic [31:0] timeout_q;
	logic [3:0]  max_retries_q;
	logic [3:0]  start_retries_q;

	// input register
	logic      valid_s1;
	in_item_t  in_s1;
	logic      accept;
	logic      advance;
	logic      room;

	// protocol state
	phase_t      phase_q, phase_d;
	logic [7:0]  byte_count_q, byte_count_d;
	logic [7:0]  exp_num_q, exp_num_d;
	logic [7:0]  hdr_start_q, hdr_start_d;
	logic [7:0]  hdr_num_q, hdr_num_d;
	logic [7:0]  hdr_cpl_q, hdr_cpl_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  crc_hi_q, crc_hi_d;
	logic [3:0]  retries_q, retries_d;
	logic        fad_q, fad_d;
	logic [31:0] timer_q, timer_d;

	// decode
	logic        p0_v, p1_v;
	res_item_t   p0, p1;
	logic        end_att, begin_att;
	logic [7:0]  att_resp;
	logic [1:0]  att_vd;
	logic [3:0]  ret_dec;
	logic [31:0] lim, timer_inc;
	logic        expired, good;
	logic [7:0]  b;
	logic [1:0]  st;
	res_pair_t   pair, wr;

	assign accept   = in_valid && !in_stall;
	assign advance  = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign b        = in_s1.rx_byte;

	// register zero is read as one
	assign lim       = (timeout_q == 32'd0) ? 32'd1 : timeout_q;
	assign timer_inc = (timer_q == 32'hFFFF_FFFF) ? timer_q : timer_q + 32'd1;
	assign expired   = (timer_inc >= lim);
	assign good      = (hdr_start_q == CH_SOH) && ((hdr_num_q ^ hdr_cpl_q) == 8'hFF)
			&& ({crc_hi_q, b} == crc_q);

	always_comb begin
		phase_d      = phase_q;
		byte_count_d = byte_count_q;
		exp_num_d    = exp_num_q;
		hdr_start_d  = hdr_start_q;
		hdr_num_d    = hdr_num_q;
		hdr_cpl_d    = hdr_cpl_q;
		crc_d        = crc_q;
		crc_hi_d     = crc_hi_q;
		retries_d    = retries_q;
		fad_d        = fad_q;
		timer_d      = timer_q;
		p0_v         = 1'b0;
		p0           = '0;
		p1_v         = 1'b0;
		p1           = '0;
		end_att      = 1'b0;
		begin_att    = 1'b0;
		att_resp     = CH_NONE;
		att_vd       = VD_NONE;
		ret_dec      = retries_q;

		case (in_s1.opcode)
			OP_START: begin
				phase_d     = PH_RECV;
				exp_num_d   = 8'd1;
				fad_d       = 1'b0;
				retries_d   = (start_retries_q == 4'd0) ? 4'd1 : start_retries_q;
				hdr_start_d = 8'd0;
				hdr_num_d   = 8'd0;
				hdr_cpl_d   = 8'd0;
				crc_hi_d    = 8'd0;
				begin_att   = 1'b1;
			end
			OP_BYTE: begin
				if (phase_q == PH_RECV) begin
					timer_d      = 32'd0;
					byte_count_d = byte_count_q + 8'd1;
					if (byte_count_q == 8'd0) begin
						hdr_start_d = b;
						// lone EOT: end of transfer
						if (b == CH_EOT) begin
							p0_v         = 1'b1;
							p0           = mk_res(CH_ACK, 1'b0, 8'd0, 7'd0, VD_NONE);
							phase_d      = PH_TRAIL;
							byte_count_d = byte_count_q;
						end
					end else if (byte_count_q == POS_NUMBER) begin
						hdr_num_d = b;
					end else if (byte_count_q == POS_COMPLEMENT) begin
						hdr_cpl_d = b;
					end else if (byte_count_q < POS_CRC_HIGH) begin
						crc_d = crc_byte(crc_q, b);
						p0_v  = 1'b1;
						p0    = mk_res(CH_NONE, 1'b1, b,
								7'(byte_count_q - POS_DATA_FIRST), VD_NONE);
					end else if (byte_count_q == POS_CRC_HIGH) begin
						crc_hi_d = b;
					end else begin
						// final CRC byte: verdict
						if (!good) begin
							end_att  = 1'b1;
							att_resp = fad_q ? CH_NAK : CH_NONE;
							att_vd   = VD_DROP;
						end else if (hdr_num_q == exp_num_q) begin
							p0_v      = 1'b1;
							p0        = mk_res(CH_ACK, 1'b0, 8'd0, 7'd0, VD_COMMIT);
							exp_num_d = exp_num_q + 8'd1;
							retries_d = (max_retries_q == 4'd0) ? 4'd1 : max_retries_q;
							fad_d     = 1'b1;
							begin_att = 1'b1;
						end else if (hdr_num_q == exp_num_q - 8'd1) begin
							end_att  = 1'b1;
							att_resp = CH_ACK;
							att_vd   = VD_DROP;
						end else begin
							end_att  = 1'b1;
							att_resp = CH_NAK;
							att_vd   = VD_DROP;
						end
					end
				end else if (phase_q == PH_TRAIL) begin
					timer_d = 32'd0;
					if (b == CH_EOT) begin
						p0_v = 1'b1;
						p0   = mk_res(CH_ACK, 1'b0, 8'd0, 7'd0, VD_NONE);
					end
				end
			end
			OP_TICK: begin
				if (phase_q == PH_RECV) begin
					timer_d = timer_inc;
					if (expired) begin
						end_att  = 1'b1;
						att_resp = fad_q ? CH_NAK : CH_NONE;
						att_vd   = (byte_count_q > POS_DATA_FIRST) ? VD_DROP : VD_NONE;
					end
				end else if (phase_q == PH_TRAIL) begin
					timer_d = timer_inc;
					if (expired) begin
						phase_d = PH_OK;
						timer_d = 32'd0;
					end
				end
			end
			default: begin
			end
		endcase

		// attempt ends: response, one retry used, fail or retry
		if (end_att) begin
			p0_v = (att_resp != CH_NONE) || (att_vd != VD_NONE);
			p0   = mk_res(att_resp, 1'b0, 8'd0, 7'd0, att_vd);
			if (retries_q != 4'd0)
				ret_dec = retries_q - 4'd1;
			retries_d = ret_dec;
			if (ret_dec == 4'd0) begin
				phase_d      = PH_FAIL;
				byte_count_d = 8'd0;
				timer_d      = 32'd0;
			end else begin
				begin_att = 1'b1;
			end
		end

		// new attempt: C until the first block is in
		if (begin_att) begin
			byte_count_d = 8'd0;
			timer_d      = 32'd0;
			crc_d        = 16'd0;
			if (!fad_d) begin
				p1_v = 1'b1;
				p1   = mk_res(CH_C, 1'b0, 8'd0, 7'd0, VD_NONE);
			end
		end
	end

	always_comb begin
		case (phase_d)
			PH_IDLE: st = ST_IDLE;
			PH_OK:   st = ST_OK;
			PH_FAIL: st = ST_FAIL;
			default: st = ST_BUSY;
		endcase

		pair = '0;
		if (p0_v) begin
			pair.r0 = p0;
			pair.r1 = p1;
			pair.n  = p1_v ? 2'd2 : 2'd1;
		end else begin
			// an empty request still reports status
			pair.r0 = p1_v ? p1 : res_item_t'('0);
			pair.n  = 2'd1;
		end
		pair.r0.status = st;
		pair.r1.status = st;
		pair.r0.last   = (pair.n == 2'd1);
		pair.r1.last   = 1'b1;

		wr   = pair;
		wr.n = advance ? pair.n : 2'd0;
	end

	// configuration writes; unknown index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q       <= 32'd1000;
			max_retries_q   <= 4'd4;
			start_retries_q <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TIMEOUT:       timeout_q       <= cfg_data;
				CFG_MAX_RETRIES:   max_retries_q   <= cfg_data[3:0];
				CFG_START_RETRIES: start_retries_q <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept)
			in_s1 <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			byte_count_q <= 8'd0;
			exp_num_q    <= 8'd1;
			hdr_start_q  <= 8'd0;
			hdr_num_q    <= 8'd0;
			hdr_cpl_q    <= 8'd0;
			crc_q        <= 16'd0;
			crc_hi_q     <= 8'd0;
			retries_q    <= 4'd0;
			fad_q        <= 1'b0;
			timer_q      <= 32'd0;
		end else if (advance) begin
			phase_q      <= phase_d;
			byte_count_q <= byte_count_d;
			exp_num_q    <= exp_num_d;
			hdr_start_q  <= hdr_start_d;
			hdr_num_q    <= hdr_num_d;
			hdr_cpl_q    <= hdr_cpl_d;
			crc_q        <= crc_d;
			crc_hi_q     <= crc_hi_d;
			retries_q    <= retries_d;
			fad_q        <= fad_d;
			timer_q      <= timer_d;
		end
	end

	xcrc_res_fifo #(
		.DEPTH(RES_DEPTH)
	) u_res_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.room     (room),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	// a decoded request always leaves a result to offer
	a_adv_out: assert property (@(posedge clk) disable iff (!arst_n)
			advance |=> out_valid)
		else $error("decoded request left no result");

	// receiving always has at least one attempt left
	a_retries: assert property (@(posedge clk) disable iff (!arst_n)
			(phase_q == PH_RECV) |-> (retries_q != 4'd0))
		else $error("receiving with no attempts left");

	// frame position only moves while receiving
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
			(phase_q != PH_RECV) |-> (byte_count_q == 8'd0))
		else $error("frame position set outside receive");

endmodule

// ----- sim/tb_top.sv -----
module tb_top;

	import xcrc_pkg::*;

	// total requests after which the random sessions stop
	localparam int REQUEST_GOAL = 1400;

	typedef enum {FR_CLEAN, FR_BAD_SOH, FR_BAD_CMP, FR_BAD_CRC} frame_fault_t;
	typedef enum {PAY_RANDOM, PAY_ZERO, PAY_ONES} payload_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	in_item_t    in_data   = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	res_item_t   out_data;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = CFG_TIMEOUT;
	logic [31:0] cfg_data  = '0;

	// burst control: 0 switches a side's idling off, N gives roughly 1-in-N odds per slot
	int gap_odds   = 0;
	int stall_odds = 0;
	int stall_left = 0;

	int requests_sent = 0;
	int mismatches    = 0;

	// receiver state as this bench sees it
	phase_t      rx_phase;
	logic [7:0]  frame_pos;
	logic [7:0]  want_num;
	logic [7:0]  got_start;
	logic [7:0]  got_num;
	logic [7:0]  got_cmp;
	logic [7:0]  got_crc_hi;
	logic [15:0] run_crc;
	logic [3:0]  tries_left;
	logic        acked_once;
	logic [31:0] quiet_ticks;

	// register copies
	logic [31:0] lim_ticks;
	logic [3:0]  lim_retries;
	logic [3:0]  lim_start;

	res_item_t step_out[$];      // results of the request being stepped
	res_item_t owed_results[$];  // results the block still owes, oldest first

	always #2 clk = ~clk;

	xmodem_crc_receiver dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ------------------------------------------------------------------
	// Receiver behaviour
	// ------------------------------------------------------------------

	// CRC-16/XMODEM, one byte, bit at a time: feedback is msb of crc xor data bit
	function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] x;
		int          k;
		x = c;
		for (k = 7; k >= 0; k--) begin
			if (x[15] ^ b[k])
				x = {x[14:0], 1'b0} ^ CRC_POLY;
			else
				x = {x[14:0], 1'b0};
		end
		return x;
	endfunction

	// queue one result; data fields read as zero unless the data flag is set
	function automatic void note(input logic [7:0] tx, input logic dv, input logic [7:0] db,
			input logic [6:0] di, input logic [1:0] vd);
		res_item_t r;
		if (step_out.size() >= 2)
			return;
		r            = '0;
		r.tx_valid   = (tx != CH_NONE);
		r.tx_byte    = tx;
		r.data_valid = dv;
		r.data_byte  = dv ? db : 8'h00;
		r.data_index = dv ? di : 7'd0;
		r.verdict    = vd;
		step_out.push_back(r);
	endfunction

	// a fresh attempt; C goes out only until the first block is in
	function automatic void open_attempt();
		frame_pos   = '0;
		quiet_ticks = '0;
		run_crc     = '0;
		if (!acked_once)
			note(CH_C, 1'b0, 8'h00, 7'd0, VD_NONE);
	endfunction

	function automatic void close_attempt(input logic [7:0] resp, input logic [1:0] vd);
		if (resp != CH_NONE || vd != VD_NONE)
			note(resp, 1'b0, 8'h00, 7'd0, vd);
		if (tries_left != 0)
			tries_left--;
		if (tries_left == 0) begin
			rx_phase    = PH_FAIL;
			frame_pos   = '0;
			quiet_ticks = '0;
		end else begin
			open_attempt();
		end
	endfunction

	function automatic void take_byte(input logic [7:0] b);
		logic [7:0]  pos;
		logic [15:0] got;
		pos         = frame_pos;
		quiet_ticks = '0;
		if (pos == 8'd0) begin
			got_start = b;
			// lone EOT in place of a frame: end of transfer
			if (b == CH_EOT) begin
				note(CH_ACK, 1'b0, 8'h00, 7'd0, VD_NONE);
				rx_phase = PH_TRAIL;
				return;
			end
		end else if (pos == POS_NUMBER) begin
			got_num = b;
		end else if (pos == POS_COMPLEMENT) begin
			got_cmp = b;
		end else if (pos < POS_CRC_HIGH) begin
			run_crc = crc16_step(run_crc, b);
			note(CH_NONE, 1'b1, b, 7'(pos - POS_DATA_FIRST), VD_NONE);
		end else if (pos == POS_CRC_HIGH) begin
			got_crc_hi = b;
		end else begin
			got = {got_crc_hi, b};
			if (!(got_start == CH_SOH && (got_num ^ got_cmp) == 8'hFF && got == run_crc)) begin
				close_attempt(acked_once ? CH_NAK : CH_NONE, VD_DROP);
			end else if (got_num == want_num) begin
				note(CH_ACK, 1'b0, 8'h00, 7'd0, VD_COMMIT);
				want_num   = want_num + 8'd1;
				tries_left = (lim_retries == 0) ? 4'd1 : lim_retries;
				acked_once = 1'b1;
				open_attempt();
			end else if (got_num == 8'(want_num - 8'd1)) begin
				// repeat of the block just taken
				close_attempt(CH_ACK, VD_DROP);
			end else begin
				close_attempt(CH_NAK, VD_DROP);
			end
			return;
		end
		frame_pos = pos + 8'd1;
	endfunction

	// counter saturates; a zero limit behaves as one
	function automatic logic tick_expired();
		logic [31:0] lim;
		lim = (lim_ticks == 0) ? 32'd1 : lim_ticks;
		if (quiet_ticks != 32'hFFFF_FFFF)
			quiet_ticks++;
		return quiet_ticks >= lim;
	endfunction

	function automatic void receiver_reset();
		lim_ticks   = 32'd1000;
		lim_retries = 4'd4;
		lim_start   = 4'd1;
		rx_phase    = PH_IDLE;
		frame_pos   = '0;
		want_num    = 8'd1;
		got_start   = '0;
		got_num     = '0;
		got_cmp     = '0;
		got_crc_hi  = '0;
		run_crc     = '0;
		tries_left  = '0;
		acked_once  = 1'b0;
		quiet_ticks = '0;
		owed_results.delete();
	endfunction

	// one accepted request: update state, append its results to owed_results
	function automatic void receiver_step(input in_item_t it);
		res_item_t  r;
		logic [1:0] st;
		int         k;
		step_out.delete();
		case (it.opcode)
			OP_START: begin
				rx_phase   = PH_RECV;
				want_num   = 8'd1;
				acked_once = 1'b0;
				tries_left = (lim_start == 0) ? 4'd1 : lim_start;
				got_start  = '0;
				got_num    = '0;
				got_cmp    = '0;
				got_crc_hi = '0;
				open_attempt();
			end
			OP_BYTE: begin
				if (rx_phase == PH_RECV) begin
					take_byte(it.rx_byte);
				end else if (rx_phase == PH_TRAIL) begin
					// trailing: only EOT is answered, any byte restarts the timer
					quiet_ticks = '0;
					if (it.rx_byte == CH_EOT)
						note(CH_ACK, 1'b0, 8'h00, 7'd0, VD_NONE);
				end
			end
			OP_TICK: begin
				if (rx_phase == PH_RECV) begin
					if (tick_expired())
						close_attempt(acked_once ? CH_NAK : CH_NONE,
							(frame_pos > POS_DATA_FIRST) ? VD_DROP : VD_NONE);
				end else if (rx_phase == PH_TRAIL) begin
					if (tick_expired()) begin
						rx_phase    = PH_OK;
						quiet_ticks = '0;
					end
				end
			end
			default: ;
		endcase
		if (step_out.size() == 0)
			note(CH_NONE, 1'b0, 8'h00, 7'd0, VD_NONE);
		case (rx_phase)
			PH_IDLE: st = ST_IDLE;
			PH_OK:   st = ST_OK;
			PH_FAIL: st = ST_FAIL;
			default: st = ST_BUSY;
		endcase
		for (k = 0; k < step_out.size(); k++) begin
			r        = step_out[k];
			r.status = st;
			r.last   = (k == step_out.size() - 1);
			owed_results.push_back(r);
		end
	endfunction

	// ------------------------------------------------------------------
	// Result side: stall bursts and checking
	// ------------------------------------------------------------------

	// stall bursts, each begun at random with odds set by stall_odds
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left = stall_left - 1;
			out_stall <= 1'b1;
		end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
			stall_left = $urandom_range(0, 11);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] seen);
		if (seen !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, seen);
			mismatches++;
		end
	endtask

	// sampled at the rising edge, before the block's registers move
	always @(posedge clk) begin
		res_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (owed_results.size() == 0) begin
				$error("result with nothing outstanding: %h", out_data);
				mismatches++;
			end else begin
				want = owed_results.pop_front();
				check_field("tx_valid",   8'(want.tx_valid),   8'(out_data.tx_valid));
				check_field("tx_byte",    want.tx_byte,        out_data.tx_byte);
				check_field("data_valid", 8'(want.data_valid), 8'(out_data.data_valid));
				check_field("data_byte",  want.data_byte,      out_data.data_byte);
				check_field("data_index", 8'(want.data_index), 8'(out_data.data_index));
				check_field("verdict",    8'(want.verdict),    8'(out_data.verdict));
				check_field("status",     8'(want.status),     8'(out_data.status));
				check_field("last",       8'(want.last),       8'(out_data.last));
			end
		end
	end

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	// drives at the falling edge, returns at the accepting rising edge with valid
	// still high, so back-to-back requests keep valid high unless a random gap is drawn
	task automatic send_request(input logic [1:0] op, input logic [7:0] b);
		in_item_t it;
		int       gap;
		it.opcode  = op;
		it.rx_byte = b;
		@(negedge clk);
		if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		receiver_step(it);
		requests_sent++;
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_request(OP_TICK, 8'($urandom));
	endtask

	// enough ticks to run out the current timer; only for small limits
	task automatic expire();
		send_ticks((lim_ticks == 0) ? 1 : int'(lim_ticks));
	endtask

	// now and then a few ticks between bytes, never enough to time out
	task automatic maybe_ticks();
		int cap;
		if (lim_ticks > 1 && $urandom_range(0, 15) == 0) begin
			cap = (lim_ticks > 32'd4) ? 3 : int'(lim_ticks) - 1;
			send_ticks($urandom_range(1, cap));
		end
	endtask

	// drop valid, let every owed result drain, then a few cycles of margin
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (owed_results.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	// all three registers, one per cycle; only while the block is quiet
	task automatic set_regs(input logic [31:0] t, input logic [3:0] m, input logic [3:0] s);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_TIMEOUT;
		cfg_data  <= t;
		@(negedge clk);
		cfg_index <= CFG_MAX_RETRIES;
		cfg_data  <= {28'd0, m};
		@(negedge clk);
		cfg_index <= CFG_START_RETRIES;
		cfg_data  <= {28'd0, s};
		@(negedge clk);
		cfg_we <= 1'b0;
		lim_ticks   = t;
		lim_retries = m;
		lim_start   = s;
	endtask

	// full 133-byte frame, optionally spoilt in one place
	task automatic send_frame(input logic [7:0] num, input frame_fault_t fault,
			input payload_t fill);
		logic [7:0]  body [BLOCK_BYTES];
		logic [15:0] crc;
		logic [7:0]  head;
		logic [7:0]  cmp;
		int          i;
		crc = '0;
		for (i = 0; i < BLOCK_BYTES; i++) begin
			case (fill)
				PAY_ZERO: body[i] = 8'h00;
				PAY_ONES: body[i] = 8'hFF;
				default:  body[i] = 8'($urandom);
			endcase
			crc = crc16_step(crc, body[i]);
		end
		head = CH_SOH;
		cmp  = ~num;
		case (fault)
			FR_BAD_SOH: begin
				// anything but SOH, and not EOT either, which would end the transfer
				head = 8'($urandom_range(2, 255));
				if (head == CH_EOT)
					head = 8'hFF;
			end
			FR_BAD_CMP: cmp = cmp ^ 8'($urandom_range(1, 255));
			FR_BAD_CRC: crc = crc ^ 16'($urandom_range(1, 65535));
			default: ;
		endcase
		send_request(OP_BYTE, head);
		maybe_ticks();
		send_request(OP_BYTE, num);
		send_request(OP_BYTE, cmp);
		for (i = 0; i < BLOCK_BYTES; i++) begin
			maybe_ticks();
			send_request(OP_BYTE, body[i]);
		end
		send_request(OP_BYTE, crc[15:8]);
		send_request(OP_BYTE, crc[7:0]);
	endtask

	// header plus n payload bytes, then silence until the attempt times out
	task automatic send_partial(input logic [7:0] num, input int n);
		send_request(OP_BYTE, CH_SOH);
		send_request(OP_BYTE, num);
		send_request(OP_BYTE, ~num);
		repeat (n) send_request(OP_BYTE, 8'($urandom));
		expire();
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// straight after reset: bytes and ticks fall on deaf ears
	task automatic test_idle_ignored();
		send_request(OP_BYTE, 8'h00);
		send_request(OP_BYTE, 8'hFF);
		send_request(OP_TICK, 8'h00);
	endtask

	// EOT ends the transfer; trailing EOTs ACKed, other bytes ignored, quiet ends it
	task automatic test_end_of_transfer();
		settle();
		set_regs(32'd2, 4'd3, 4'd1);
		send_request(OP_START, 8'h00);
		send_request(OP_BYTE, CH_EOT);
		send_request(OP_BYTE, 8'h55);
		send_request(OP_BYTE, CH_EOT);
		send_ticks(2);
		send_request(OP_BYTE, 8'hFF);
		send_request(OP_TICK, 8'hFF);
	endtask

	// timeout before any block, single start attempt: fails silently
	task automatic test_start_failure();
		send_request(OP_START, 8'hFF);
		send_request(OP_BYTE, CH_SOH);
		send_request(OP_BYTE, 8'h01);
		send_ticks(2);
		send_request(OP_BYTE, CH_SOH);
	endtask

	// start mid-frame throws the frame away and begins again
	task automatic test_restart();
		send_request(OP_START, 8'h00);
		send_request(OP_BYTE, CH_SOH);
		send_request(OP_START, 8'hFF);
	endtask

	// zero in every register behaves as one
	task automatic test_zero_registers();
		settle();
		set_regs(32'd0, 4'd0, 4'd0);
		gap_odds   = 6;
		stall_odds = 6;
		send_request(OP_START, 8'h00);
		send_request(OP_TICK, 8'h00);
		send_request(OP_START, 8'h00);
		send_frame(8'd1, FR_CLEAN, PAY_RANDOM);
		send_frame(8'd1, FR_CLEAN, PAY_RANDOM);
	endtask

	// fifteen attempts at each stage, used up by timeouts
	task automatic test_retry_limits();
		settle();
		set_regs(32'd1, 4'd15, 4'd15);
		send_request(OP_START, 8'h00);
		send_ticks(15);
		send_request(OP_START, 8'h00);
		send_frame(8'd1, FR_CLEAN, PAY_RANDOM);
		send_ticks(15);
	endtask

	// a bad CRC before the first block; wrong number, bad SOH, bad complement and timeout after it
	task automatic test_frame_errors();
		settle();
		set_regs(32'd3, 4'd15, 4'd2);
		gap_odds   = 0;
		stall_odds = 0;
		send_request(OP_START, 8'h00);
		send_frame(8'd1, FR_BAD_CRC, PAY_RANDOM);
		send_frame(8'd1, FR_CLEAN, PAY_ZERO);
		gap_odds   = 5;
		stall_odds = 5;
		send_frame(8'd9, FR_CLEAN, PAY_RANDOM);
		send_frame(8'd2, FR_BAD_SOH, PAY_RANDOM);
		send_frame(8'd2, FR_BAD_CMP, PAY_ONES);
		send_partial(8'd2, 20);
		send_frame(8'd2, FR_CLEAN, PAY_RANDOM);
		send_request(OP_BYTE, CH_EOT);
		send_request(OP_BYTE, CH_EOT);
		send_request(OP_BYTE, 8'($urandom));
		expire();
	endtask

	// whole transfers, with random registers after the first; mostly clean frames in order
	task automatic test_random_sessions();
		int pick;
		int n;
		int s;
		s = 0;
		while (requests_sent < REQUEST_GOAL) begin
			settle();
			if (s == 0)
				set_regs(32'hFFFF_FFFF, 4'd1, 4'd15);
			else
				set_regs($urandom_range(1, 6), 4'($urandom_range(1, 15)),
					4'($urandom_range(1, 15)));
			// last stretch runs flat out
			if (requests_sent > REQUEST_GOAL - 250) begin
				gap_odds   = 0;
				stall_odds = 0;
			end else begin
				gap_odds   = $urandom_range(0, 1) ? 6 : 0;
				stall_odds = $urandom_range(0, 1) ? 6 : 0;
			end
			send_request(OP_START, 8'($urandom));
			while (rx_phase == PH_RECV && requests_sent < REQUEST_GOAL) begin
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					send_frame(want_num, FR_CLEAN, PAY_RANDOM);
				end else if (pick < 62) begin
					send_frame(want_num - 8'd1, FR_CLEAN, PAY_RANDOM);
				end else if (pick < 67) begin
					send_frame(want_num + 8'($urandom_range(1, 254)), FR_CLEAN, PAY_RANDOM);
				end else if (pick < 77) begin
					send_frame(want_num, frame_fault_t'($urandom_range(1, 3)), PAY_RANDOM);
				end else if (pick < 85 && lim_ticks <= 6) begin
					send_partial(want_num, $urandom_range(0, 40));
				end else if (pick < 90) begin
					send_request(OP_START, 8'($urandom));
				end else begin
					send_request(OP_BYTE, CH_EOT);
					n = $urandom_range(0, 4);
					repeat (n)
						send_request(OP_BYTE, $urandom_range(0, 1) ? CH_EOT : 8'($urandom));
					if (lim_ticks <= 6)
						expire();
				end
			end
			s++;
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		receiver_reset();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		gap_odds   = 4;
		stall_odds = 4;
		test_idle_ignored();
		test_end_of_transfer();
		test_start_failure();
		test_restart();
		test_zero_registers();
		test_retry_limits();
		test_frame_errors();
		test_random_sessions();
		settle();
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// hang guard, many times the slowest legal run
	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
sv/xcrc_pkg.sv
sv/xcrc_res_fifo.sv
sv/xmodem_crc_receiver.sv
sim/tb_top.sv
